// ===== design/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector package
// Shared widths, register indexes, status codes and payload structs.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int ANGLE_W  = 9;
    localparam int STEP_W   = 8;
    localparam int DIST_W   = 10;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    // register reset values
    localparam logic [ANGLE_W-1:0] SWEEP_LO_RST     = 9'd0;
    localparam logic [ANGLE_W-1:0] SWEEP_HI_RST     = 9'd180;
    localparam logic [ANGLE_W-1:0] CENTER_ANGLE_RST = 9'd90;
    localparam logic [STEP_W-1:0]  STEP_DEG_RST     = 8'd10;
    localparam logic [DIST_W-1:0]  DETECT_MIN_RST   = 10'd2;
    localparam logic [DIST_W-1:0]  DETECT_MAX_RST   = 10'd50;
    localparam logic [DIST_W-1:0]  NEAR_RST         = 10'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWEEP_LO     = 3'd0,
        CFG_SWEEP_HI     = 3'd1,
        CFG_CENTER_ANGLE = 3'd2,
        CFG_STEP_DEG     = 3'd3,
        CFG_DETECT_MIN   = 3'd4,
        CFG_DETECT_MAX   = 3'd5,
        CFG_NEAR         = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_SCAN   = 2'd0,
        ST_DETECT = 2'd1,
        ST_ALERT  = 2'd2
    } t_scan_status;

    typedef struct packed {
        logic [ANGLE_W-1:0] sweep_lo;
        logic [ANGLE_W-1:0] sweep_hi;
        logic [ANGLE_W-1:0] center_angle;
        logic [STEP_W-1:0]  step_deg;
        logic [DIST_W-1:0]  detect_min_cm;
        logic [DIST_W-1:0]  detect_max_cm;
        logic [DIST_W-1:0]  near_cm;
    } t_cfg;

    typedef struct packed {
        logic              enabled;
        logic [DIST_W-1:0] range_cm;
        logic              range_ok;
    } t_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] meas_angle;
        logic [DIST_W-1:0]  distance_out;
        logic               distance_ok;
        logic               object_seen;
        logic               near_alarm;
        t_scan_status       scan_status;
        logic [COUNT_W-1:0] objects_counted;
        logic [DIST_W-1:0]  last_hit_cm;
        logic [ANGLE_W-1:0] last_hit_angle;
        logic               scan_lamp;
        logic               buzzer;
        logic               alert_lamp;
    } t_result;

endpackage

// ===== design/ssd_in_if.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector input channel
// Valid/ready channel carrying one range measurement or stop request.
// ----------------------------------------------------------------------------
interface ssd_in_if;
    import ssd_pkg::*;

    logic              valid;
    logic              ready;
    logic              enabled;
    logic [DIST_W-1:0] range_cm;
    logic              range_ok;

    modport source (output valid, enabled, range_cm, range_ok, input ready);
    modport sink   (input valid, enabled, range_cm, range_ok, output ready);
endinterface

// ===== design/ssd_out_if.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector result channel
// Valid/ready channel carrying one classified measurement result.
// ----------------------------------------------------------------------------
interface ssd_out_if;
    import ssd_pkg::*;

    logic               valid;
    logic               ready;
    logic [ANGLE_W-1:0] meas_angle;
    logic [DIST_W-1:0]  distance_out;
    logic               distance_ok;
    logic               object_seen;
    logic               near_alarm;
    logic [1:0]         scan_status;
    logic [COUNT_W-1:0] objects_counted;
    logic [DIST_W-1:0]  last_hit_cm;
    logic [ANGLE_W-1:0] last_hit_angle;
    logic               scan_lamp;
    logic               buzzer;
    logic               alert_lamp;

    modport source (
        output valid, meas_angle, distance_out, distance_ok, object_seen, near_alarm,
               scan_status, objects_counted, last_hit_cm, last_hit_angle,
               scan_lamp, buzzer, alert_lamp,
        input  ready
    );
    modport sink (
        input  valid, meas_angle, distance_out, distance_ok, object_seen, near_alarm,
               scan_status, objects_counted, last_hit_cm, last_hit_angle,
               scan_lamp, buzzer, alert_lamp,
        output ready
    );
endinterface

// ===== design/sweep_scan_detector.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector
// Range classification, hit tracking and ping-pong sweep sequencing.
// ----------------------------------------------------------------------------
// Usage: the block takes one measurement per clock while the output is not
// stalled and returns one result per measurement, in order. A transfer on
// the input lands in an input register; once the result register is free or
// being taken, the core classifies the held item, updates the hit count, last
// hit, scan lamp and sweep angle, and loads the result register. Throughput
// is one item per cycle while the consumer keeps taking results. The input
// register keeps accepting while a finished result waits on the output, so
// a stalled consumer only blocks the input once both registers are full.
// Write configuration only while no item is in flight; a register change
// does not move the sweep until the next stop or out-of-window correction.
// ----------------------------------------------------------------------------
module sweep_scan_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ssd_in_if.sink                          i_in,
    ssd_out_if.source                       o_out
);
    import ssd_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_result core_res;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    logic    move;

    ssd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // advance the held item into the result register when that slot frees up
    assign move       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || move;

    assign in_item.enabled  = i_in.enabled;
    assign in_item.range_cm = i_in.range_cm;
    assign in_item.range_ok = i_in.range_ok;

    ssd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (move),
        .i_item   (r_in_item),
        .o_result (core_res)
    );

    // input register: valid bit under reset, payload loads on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= in_item;
        end
    end

    // result register: hold until the consumer takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.meas_angle      = r_out.meas_angle;
    assign o_out.distance_out    = r_out.distance_out;
    assign o_out.distance_ok     = r_out.distance_ok;
    assign o_out.object_seen     = r_out.object_seen;
    assign o_out.near_alarm      = r_out.near_alarm;
    assign o_out.scan_status     = r_out.scan_status;
    assign o_out.objects_counted = r_out.objects_counted;
    assign o_out.last_hit_cm     = r_out.last_hit_cm;
    assign o_out.last_hit_angle  = r_out.last_hit_angle;
    assign o_out.scan_lamp       = r_out.scan_lamp;
    assign o_out.buzzer          = r_out.buzzer;
    assign o_out.alert_lamp      = r_out.alert_lamp;

    // a held item is never lost or overwritten while it waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !move |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost or changed a waiting item");

    // every item moved forward shows up as a valid result
    a_move_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_valid)
        else $error("moved item did not reach the result register");

    // a near alarm is always a detected object with alert status
    a_near_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.near_alarm |->
            r_out.object_seen && (r_out.scan_status == ST_ALERT))
        else $error("near alarm without detection or alert status");

    // a stop result sits at center with no detection and the lamp off
    a_stop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && !r_in_item.enabled |->
            !core_res.object_seen && !core_res.scan_lamp
            && (core_res.meas_angle == cfg.center_angle))
        else $error("stop result reported a detection, lamp or off-center angle");
endmodule

// ===== design/ssd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector configuration registers
// Write-only register file holding sweep limits and distance thresholds.
// ----------------------------------------------------------------------------
module ssd_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ssd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ssd_pkg::t_cfg                   o_cfg
);
    import ssd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SWEEP_LO:     n_cfg.sweep_lo      = i_cfg_data[ANGLE_W-1:0];
                CFG_SWEEP_HI:     n_cfg.sweep_hi      = i_cfg_data[ANGLE_W-1:0];
                CFG_CENTER_ANGLE: n_cfg.center_angle  = i_cfg_data[ANGLE_W-1:0];
                CFG_STEP_DEG:     n_cfg.step_deg      = i_cfg_data[STEP_W-1:0];
                CFG_DETECT_MIN:   n_cfg.detect_min_cm = i_cfg_data[DIST_W-1:0];
                CFG_DETECT_MAX:   n_cfg.detect_max_cm = i_cfg_data[DIST_W-1:0];
                CFG_NEAR:         n_cfg.near_cm       = i_cfg_data[DIST_W-1:0];
                default:          n_cfg = r_cfg;   // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sweep_lo      <= SWEEP_LO_RST;
            r_cfg.sweep_hi      <= SWEEP_HI_RST;
            r_cfg.center_angle  <= CENTER_ANGLE_RST;
            r_cfg.step_deg      <= STEP_DEG_RST;
            r_cfg.detect_min_cm <= DETECT_MIN_RST;
            r_cfg.detect_max_cm <= DETECT_MAX_RST;
            r_cfg.near_cm       <= NEAR_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== design/ssd_core.sv =====
// ----------------------------------------------------------------------------
// Sweep scan detector core
// Classifies one measurement, updates hit tracking and advances the sweep.
// ----------------------------------------------------------------------------
module ssd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssd_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  ssd_pkg::t_item   i_item,
    output ssd_pkg::t_result o_result
);
    import ssd_pkg::*;

    logic [ANGLE_W-1:0] r_sweep, n_sweep;
    logic               r_up, n_up;
    logic               r_was_det, n_was_det;
    logic               r_lamp, n_lamp;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [DIST_W-1:0]  r_hit_cm, n_hit_cm;
    logic [ANGLE_W-1:0] r_hit_ang, n_hit_ang;

    logic               out_win;
    logic [ANGLE_W-1:0] cur_angle;
    logic               cur_up;
    logic [DIST_W-1:0]  meas_cm;
    logic               seen;
    logic               near_f;
    logic [ANGLE_W:0]   up_sum;
    logic [ANGLE_W:0]   dn_lim;

    always_comb begin
        // pull an out-of-window angle back to center, sweeping up
        out_win   = (r_sweep < i_cfg.sweep_lo) || (r_sweep > i_cfg.sweep_hi);
        cur_angle = out_win ? i_cfg.center_angle : r_sweep;
        cur_up    = out_win ? 1'b1 : r_up;

        meas_cm = i_item.range_ok ? i_item.range_cm : '0;
        seen    = i_item.range_ok && (i_item.range_cm >= i_cfg.detect_min_cm)
                  && (i_item.range_cm <= i_cfg.detect_max_cm);
        near_f  = seen && (i_item.range_cm <= i_cfg.near_cm);

        up_sum = {1'b0, cur_angle} + {{(ANGLE_W+1-STEP_W){1'b0}}, i_cfg.step_deg};
        dn_lim = {1'b0, i_cfg.sweep_lo} + {{(ANGLE_W+1-STEP_W){1'b0}}, i_cfg.step_deg};

        n_sweep   = r_sweep;
        n_up      = r_up;
        n_was_det = r_was_det;
        n_lamp    = r_lamp;
        n_count   = r_count;
        n_hit_cm  = r_hit_cm;
        n_hit_ang = r_hit_ang;

        o_result                 = '0;
        o_result.objects_counted = r_count;
        o_result.last_hit_cm     = r_hit_cm;
        o_result.last_hit_angle  = r_hit_ang;
        o_result.scan_status     = ST_SCAN;

        if (!i_item.enabled) begin
            // stop: report held hit data, return sweep to center
            o_result.meas_angle = i_cfg.center_angle;
            n_sweep   = i_cfg.center_angle;
            n_up      = 1'b1;
            n_was_det = 1'b0;
        end else begin
            if (seen && !r_was_det) begin
                n_count = r_count + 1'b1;
            end
            if (seen) begin
                n_hit_cm  = meas_cm;
                n_hit_ang = cur_angle;
            end
            n_was_det = seen;
            n_lamp    = !r_lamp;

            if (cur_up) begin
                if (up_sum >= {1'b0, i_cfg.sweep_hi}) begin
                    n_sweep = i_cfg.sweep_hi;
                    n_up    = 1'b0;
                end else begin
                    n_sweep = up_sum[ANGLE_W-1:0];
                    n_up    = 1'b1;
                end
            end else begin
                if (dn_lim >= {1'b0, cur_angle}) begin
                    n_sweep = i_cfg.sweep_lo;
                    n_up    = 1'b1;
                end else begin
                    n_sweep = cur_angle - {{(ANGLE_W-STEP_W){1'b0}}, i_cfg.step_deg};
                    n_up    = 1'b0;
                end
            end

            o_result.meas_angle      = cur_angle;
            o_result.distance_out    = meas_cm;
            o_result.distance_ok     = i_item.range_ok;
            o_result.object_seen     = seen;
            o_result.near_alarm      = near_f;
            o_result.scan_status     = near_f ? ST_ALERT : (seen ? ST_DETECT : ST_SCAN);
            o_result.objects_counted = n_count;
            o_result.last_hit_cm     = n_hit_cm;
            o_result.last_hit_angle  = n_hit_ang;
            o_result.scan_lamp       = n_lamp;
            o_result.buzzer          = near_f;
            o_result.alert_lamp      = seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep   <= CENTER_ANGLE_RST;
            r_up      <= 1'b1;
            r_was_det <= 1'b0;
            r_lamp    <= 1'b0;
            r_count   <= '0;
            r_hit_cm  <= '0;
            r_hit_ang <= '0;
        end else if (i_step) begin
            r_sweep   <= n_sweep;
            r_up      <= n_up;
            r_was_det <= n_was_det;
            r_lamp    <= n_lamp;
            r_count   <= n_count;
            r_hit_cm  <= n_hit_cm;
            r_hit_ang <= n_hit_ang;
        end
    end
endmodule
